[rtl/core/qepe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qepe_pkg
// Shared types, constants and saturation helpers for the quadratic edge
// point evaluator.
// ----------------------------------------------------------------------------
package qepe_pkg;

  // One in Q16.16 and Q1.16.
  localparam int OneQ16 = 65536;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    REG_FIRST_X  = 3'd0,
    REG_FIRST_Y  = 3'd1,
    REG_SECOND_X = 3'd2,
    REG_SECOND_Y = 3'd3,
    REG_MID_X    = 3'd4,
    REG_MID_Y    = 3'd5
  } reg_index_t;

  // Pipeline stage counts of the root and the divider.
  localparam int SqrtSteps = 32;
  localparam int DivSteps  = 17;

  // Data that rides along the root pipeline.
  typedef struct packed {
    logic signed [31:0] gx;
    logic signed [31:0] gy;
    logic signed [31:0] e1;
    logic signed [31:0] e2;
  } sqrt_carry_t;

  // Data that rides along the divider pipeline.
  typedef struct packed {
    logic signed [31:0] gx;
    logic signed [31:0] gy;
    logic        [31:0] j;
    logic               neg1;
    logic               neg2;
  } div_carry_t;

  // Saturate a signed 40-bit value to signed 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [39:0] hi_lim;
    logic signed [39:0] lo_lim;
    hi_lim = 40'sh00_7FFF_FFFF;
    lo_lim = -40'sh00_8000_0000;
    if (v > hi_lim) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo_lim) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

[rtl/core/quadratic_edge_point_eval.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_edge_point_eval
// Evaluates a three-node quadratic curve at a local coordinate: global point,
// tangent length, unit tangent and unit normal.
// ----------------------------------------------------------------------------
// Channel   Ports                                   Direction
// command   start, busy, xi                         in (busy out)
// result    done, global_x .. degenerate            out
// config    wr_en, wr_index, wr_data                in
//
// One word enters per cycle; busy is always low. The path runs through
// five arithmetic stages, a 32-step square root pipeline and a 17-step
// divider pipeline, then the output register. The root and the divider set
// the depth. Reset clears the valid bits and the vertex registers. The
// receiver cannot stall, so a result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module quadratic_edge_point_eval
  import qepe_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [17:0] xi,
  input  logic               wr_en,
  input  logic        [2:0]  wr_index,
  input  logic        [31:0] wr_data,
  output logic               done,
  output logic signed [31:0] global_x,
  output logic signed [31:0] global_y,
  output logic        [30:0] jacobian,
  output logic signed [17:0] tangent_x,
  output logic signed [17:0] tangent_y,
  output logic signed [17:0] normal_x,
  output logic signed [17:0] normal_y,
  output logic               degenerate
);

  // Vertex registers.
  logic signed [31:0] v1x, v1y, v2x, v2y, v3x, v3y;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1x <= '0; v1y <= '0; v2x <= '0; v2y <= '0; v3x <= '0; v3y <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_FIRST_X:  v1x <= wr_data;
        REG_FIRST_Y:  v1y <= wr_data;
        REG_SECOND_X: v2x <= wr_data;
        REG_SECOND_Y: v2y <= wr_data;
        REG_MID_X:    v3x <= wr_data;
        REG_MID_Y:    v3y <= wr_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Stage 1: shape function and derivative coefficients.
  logic               s1_valid;
  logic signed [37:0] c1, c2, c3;
  logic signed [20:0] d1, d2, d3;
  logic signed [37:0] xx;
  logic signed [37:0] xs;

  always_comb begin
    xx = 38'(xi) * 38'(xi);
    xs = 38'(xi) <<< 16;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
    c1 <= xx - xs;
    c2 <= xx + xs;
    c3 <= (38'(OneQ16) * 38'(OneQ16) - xx) <<< 1;
    d1 <= (21'(xi) <<< 1) - 21'(OneQ16);
    d2 <= (21'(xi) <<< 1) + 21'(OneQ16);
    d3 <= 21'(xi) <<< 2;
  end

  // Stage 2: exact products. Each wide coefficient is split into a signed
  // upper part and an unsigned lower 19 bits to keep the multipliers narrow.
  logic               s2_valid;
  logic signed [50:0] pgx1h, pgx2h, pgx3h, pgy1h, pgy2h, pgy3h;
  logic signed [50:0] pgx1l, pgx2l, pgx3l, pgy1l, pgy2l, pgy3l;
  logic signed [52:0] pex1, pex2, pex3, pey1, pey2, pey3;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    pgx1h <= 51'($signed(c1[37:19])) * 51'(v1x);
    pgx2h <= 51'($signed(c2[37:19])) * 51'(v2x);
    pgx3h <= 51'($signed(c3[37:19])) * 51'(v3x);
    pgy1h <= 51'($signed(c1[37:19])) * 51'(v1y);
    pgy2h <= 51'($signed(c2[37:19])) * 51'(v2y);
    pgy3h <= 51'($signed(c3[37:19])) * 51'(v3y);
    pgx1l <= 51'($signed({1'b0, c1[18:0]})) * 51'(v1x);
    pgx2l <= 51'($signed({1'b0, c2[18:0]})) * 51'(v2x);
    pgx3l <= 51'($signed({1'b0, c3[18:0]})) * 51'(v3x);
    pgy1l <= 51'($signed({1'b0, c1[18:0]})) * 51'(v1y);
    pgy2l <= 51'($signed({1'b0, c2[18:0]})) * 51'(v2y);
    pgy3l <= 51'($signed({1'b0, c3[18:0]})) * 51'(v3y);
    pex1 <= 53'(d1) * 53'(v1x);
    pex2 <= 53'(d2) * 53'(v2x);
    pex3 <= 53'(d3) * 53'(v3x);
    pey1 <= 53'(d1) * 53'(v1y);
    pey2 <= 53'(d2) * 53'(v2y);
    pey3 <= 53'(d3) * 53'(v3y);
  end

  // Stage 3: sums, floor and saturation.
  logic signed [71:0] sgx, sgy;
  logic signed [54:0] sex, sey;
  logic               s3_valid;
  logic signed [31:0] s3_gx, s3_gy, s3_e1, s3_e2;

  always_comb begin
    sgx = ((72'(pgx1h) + 72'(pgx2h) + 72'(pgx3h)) <<< 19)
        + 72'(pgx1l) + 72'(pgx2l) + 72'(pgx3l);
    sgy = ((72'(pgy1h) + 72'(pgy2h) + 72'(pgy3h)) <<< 19)
        + 72'(pgy1l) + 72'(pgy2l) + 72'(pgy3l);
    sex = 55'(pex1) + 55'(pex2) - 55'(pex3);
    sey = 55'(pey1) + 55'(pey2) - 55'(pey3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_gx <= sat32(40'($signed(sgx[71:33])));
    s3_gy <= sat32(40'($signed(sgy[71:33])));
    s3_e1 <= sat32(40'($signed(sex[54:17])));
    s3_e2 <= sat32(40'($signed(sey[54:17])));
  end

  // Stage 4: squares of the tangent components.
  logic               s4_valid;
  logic        [63:0] sq1, sq2;
  sqrt_carry_t        s4_carry;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    sq1      <= 64'(64'(s3_e1) * 64'(s3_e1));
    sq2      <= 64'(64'(s3_e2) * 64'(s3_e2));
    s4_carry <= '{gx: s3_gx, gy: s3_gy, e1: s3_e1, e2: s3_e2};
  end

  // Stage 5: sum of squares feeds the root pipeline.
  logic        [63:0] rt_rem   [SqrtSteps+1];
  logic        [31:0] rt_root  [SqrtSteps+1];
  logic               rt_valid [SqrtSteps+1];
  sqrt_carry_t        rt_carry [SqrtSteps+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      rt_valid[0] <= 1'b0;
    end else begin
      rt_valid[0] <= s4_valid;
    end
    rt_rem[0]   <= sq1 + sq2;
    rt_root[0]  <= '0;
    rt_carry[0] <= s4_carry;
  end

  // Square root: one result bit per stage, most significant first.
  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    localparam int Bit = SqrtSteps - 1 - k;
    logic [63:0] trial;

    always_comb begin
      trial = (64'(rt_root[k]) << (Bit + 1)) + (64'(1) << (2 * Bit));
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        rt_valid[k+1] <= 1'b0;
      end else begin
        rt_valid[k+1] <= rt_valid[k];
      end
      if (rt_rem[k] >= trial) begin
        rt_rem[k+1]  <= rt_rem[k] - trial;
        rt_root[k+1] <= rt_root[k] | (32'(1) << Bit);
      end else begin
        rt_rem[k+1]  <= rt_rem[k];
        rt_root[k+1] <= rt_root[k];
      end
      rt_carry[k+1] <= rt_carry[k];
    end
  end

  // Divider entry: magnitudes scaled by one in Q16.
  logic        [47:0] dv_rem1  [DivSteps+1];
  logic        [47:0] dv_rem2  [DivSteps+1];
  logic        [16:0] dv_q1    [DivSteps+1];
  logic        [16:0] dv_q2    [DivSteps+1];
  logic               dv_valid [DivSteps+1];
  div_carry_t         dv_carry [DivSteps+1];
  sqrt_carry_t        rt_last;
  logic        [31:0] mag1, mag2;

  always_comb begin
    rt_last     = rt_carry[SqrtSteps];
    mag1        = rt_last.e1[31] ? 32'(-rt_last.e1) : 32'(rt_last.e1);
    mag2        = rt_last.e2[31] ? 32'(-rt_last.e2) : 32'(rt_last.e2);
    dv_valid[0] = rt_valid[SqrtSteps];
    dv_rem1[0]  = {mag1, 16'd0};
    dv_rem2[0]  = {mag2, 16'd0};
    dv_q1[0]    = '0;
    dv_q2[0]    = '0;
    dv_carry[0] = '{gx: rt_last.gx, gy: rt_last.gy, j: rt_root[SqrtSteps],
                    neg1: rt_last.e1[31], neg2: rt_last.e2[31]};
  end

  // Restoring division of both components, one quotient bit per stage.
  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    localparam int Bit = DivSteps - 1 - k;
    logic [47:0] dsh;

    always_comb begin
      dsh = 48'(dv_carry[k].j) << Bit;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[k+1] <= 1'b0;
      end else begin
        dv_valid[k+1] <= dv_valid[k];
      end
      if (dv_rem1[k] >= dsh) begin
        dv_rem1[k+1] <= dv_rem1[k] - dsh;
        dv_q1[k+1]   <= dv_q1[k] | (17'(1) << Bit);
      end else begin
        dv_rem1[k+1] <= dv_rem1[k];
        dv_q1[k+1]   <= dv_q1[k];
      end
      if (dv_rem2[k] >= dsh) begin
        dv_rem2[k+1] <= dv_rem2[k] - dsh;
        dv_q2[k+1]   <= dv_q2[k] | (17'(1) << Bit);
      end else begin
        dv_rem2[k+1] <= dv_rem2[k];
        dv_q2[k+1]   <= dv_q2[k];
      end
      dv_carry[k+1] <= dv_carry[k];
    end
  end

  // Output register: signs, degenerate case and jacobian clamp.
  div_carry_t         fin;
  logic               fin_zero;
  logic signed [17:0] tx_next, ty_next;

  always_comb begin
    fin      = dv_carry[DivSteps];
    fin_zero = (fin.j == '0);
    tx_next  = fin.neg1 ? -18'(dv_q1[DivSteps]) : 18'(dv_q1[DivSteps]);
    ty_next  = fin.neg2 ? -18'(dv_q2[DivSteps]) : 18'(dv_q2[DivSteps]);
    if (fin_zero) begin
      tx_next = '0;
      ty_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid[DivSteps];
    end
    global_x   <= fin.gx;
    global_y   <= fin.gy;
    jacobian   <= fin.j[31] ? 31'h7FFF_FFFF : fin.j[30:0];
    tangent_x  <= tx_next;
    tangent_y  <= ty_next;
    normal_x   <= ty_next;
    normal_y   <= -tx_next;
    degenerate <= fin_zero;
  end

endmodule
